[rtl/hidkb_pkg.sv]
// Shared types and constants for the HID boot keyboard report builder.
`default_nettype none

package hidkb_pkg;

    localparam int CODE_W      = 8;
    localparam int REPORT_KEYS = 6;
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = CODE_W * (REPORT_KEYS + 1);

    localparam logic [CODE_W-1:0] KEY_NONE  = 8'h00;
    localparam logic [CODE_W-1:0] MOD_FIRST = 8'hE0;
    localparam logic [CODE_W-1:0] MOD_LAST  = 8'hE7;

    localparam logic OP_KEY    = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    typedef struct packed {
        logic is_empty;
        logic is_match;
    } cmp_t;

endpackage

`default_nettype wire

[rtl/hidkb_slot_cmp.sv]
// Shared slot comparator: empty test and match against the event code.
`default_nettype none

module hidkb_slot_cmp (
    input  wire logic [hidkb_pkg::CODE_W-1:0] slot_val,
    input  wire logic [hidkb_pkg::CODE_W-1:0] code,
    output hidkb_pkg::cmp_t                    result
);
    import hidkb_pkg::*;

    assign result.is_empty = (slot_val == KEY_NONE);
    assign result.is_match = (slot_val == code);

endmodule

`default_nettype wire

[rtl/hid_boot_keyboard_report_builder_unit.sv]
// Top level of the HID boot keyboard report builder with its slot sequencer.
//
//  channel | dir | tdata fields (low bit up)                  | tuser
//  s_      | in  | key_code[7:0], pressed[8], zero pad [15:9]  | op[0]
//  m_      | out | modifiers, slot0, slot1 ... slot5 (8b each)  | -
//
// One comparator walks the slot table one entry per cycle.
// Key event with an ordinary code: accept, a scan over every slot, then the
// update step, after which the input is ready again.
// Modifier event, code zero, or report request with nothing changed: handled in idle, which stays ready.
// Report request with changes: a compaction sweep over every slot, then the output
// register is loaded once any pending result has been taken.
// Reset (aresetn low, synchronous) empties the table, clears modifiers and the
// change flag, and drops any pending result.
`default_nettype none

module hid_boot_keyboard_report_builder_unit #(
    parameter int SLOT_COUNT = 6
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    // key_code [7:0], pressed [8], zero [15:9]
    input  wire logic [hidkb_pkg::IN_TDATA_W-1:0]    s_tdata,
    // op [0]
    input  wire logic [hidkb_pkg::IN_TUSER_W-1:0]    s_tuser,
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    // modifiers [7:0], slot0 [15:8], slot1 [23:16], slot2 [31:24],
    // slot3 [39:32], slot4 [47:40], slot5 [55:48]
    output      logic [hidkb_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import hidkb_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int WR_W  = $clog2(SLOT_COUNT + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_APPLY   = 3'd2;
    localparam logic [2:0] ST_COMPACT = 3'd3;
    localparam logic [2:0] ST_EMIT    = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CODE_W-1:0] slot_reg [SLOT_COUNT];
    logic [CODE_W-1:0] slot_next [SLOT_COUNT];
    logic [CODE_W-1:0] mod_reg, mod_next;
    logic              dirty_reg, dirty_next;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [WR_W-1:0]   wr_reg, wr_next;
    logic              hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              pressed_reg, pressed_next;

    logic [CODE_W-1:0] rep_reg [REPORT_KEYS];
    logic [CODE_W-1:0] rep_next [REPORT_KEYS];

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [CODE_W-1:0] in_code;
    logic              in_pressed;
    logic              in_op;
    logic [CODE_W-1:0] cur_slot;
    cmp_t              cmp;

    assign in_code    = s_tdata[CODE_W-1:0];
    assign in_pressed = s_tdata[CODE_W];
    assign in_op      = s_tuser[0];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The one comparator, shared by the search and the compaction sweep.
    assign cur_slot = slot_reg[idx_reg];

    hidkb_slot_cmp u_cmp (
        .slot_val (cur_slot),
        .code     (code_reg),
        .result   (cmp)
    );

    always_comb begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        mod_next        = mod_reg;
        dirty_next      = dirty_reg;
        idx_next        = idx_reg;
        wr_next         = wr_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        code_next       = code_reg;
        pressed_next    = pressed_reg;
        rep_next        = rep_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;

        // Drop the result once the downstream side takes it.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_op == OP_REPORT) begin
                        // Nothing changed: no report, state untouched.
                        if (dirty_reg) begin
                            dirty_next = 1'b0;
                            idx_next   = '0;
                            wr_next    = '0;
                            for (int k = 0; k < REPORT_KEYS; k++) begin
                                rep_next[k] = KEY_NONE;
                            end
                            state_next = ST_COMPACT;
                        end
                    end else if (in_code == KEY_NONE) begin
                        // Code zero means no key: ignore the event.
                    end else if (in_code >= MOD_FIRST && in_code <= MOD_LAST) begin
                        // Modifier keys bypass the table and always mark a change.
                        if (in_pressed) begin
                            mod_next = mod_reg | (CODE_W'(1) << in_code[2:0]);
                        end else begin
                            mod_next = mod_reg & ~(CODE_W'(1) << in_code[2:0]);
                        end
                        dirty_next = 1'b1;
                    end else begin
                        code_next       = in_code;
                        pressed_next    = in_pressed;
                        idx_next        = '0;
                        hit_found_next  = 1'b0;
                        free_found_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // Record the lowest empty slot and the lowest matching slot.
                if (!free_found_reg && cmp.is_empty) begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if (!hit_found_reg && cmp.is_match) begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = idx_reg;
                end
                if (idx_reg == IDX_LAST) begin
                    state_next = ST_APPLY;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_APPLY: begin
                if (pressed_reg) begin
                    // Ignore a press of a held code or into a full table.
                    if (!hit_found_reg && free_found_reg) begin
                        slot_next[free_idx_reg] = code_reg;
                        dirty_next              = 1'b1;
                    end
                end else if (hit_found_reg) begin
                    slot_next[hit_idx_reg] = KEY_NONE;
                    dirty_next             = 1'b1;
                end
                state_next = ST_IDLE;
            end

            ST_COMPACT: begin
                // Move each held code down to the write pointer, order kept.
                if (!cmp.is_empty) begin
                    slot_next[wr_reg[IDX_W-1:0]] = cur_slot;
                    if (wr_reg[IDX_W-1:0] != idx_reg) begin
                        slot_next[idx_reg] = KEY_NONE;
                    end
                    for (int k = 0; k < REPORT_KEYS; k++) begin
                        if (8'(wr_reg) == 8'(k)) begin
                            rep_next[k] = cur_slot;
                        end
                    end
                    wr_next = wr_reg + 1'b1;
                end
                if (idx_reg == IDX_LAST) begin
                    state_next = ST_EMIT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_EMIT: begin
                // Hold until the output register is free, then load the report.
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next[CODE_W-1:0] = mod_reg;
                    for (int k = 0; k < REPORT_KEYS; k++) begin
                        m_tdata_next[CODE_W*(k+1) +: CODE_W] = rep_reg[k];
                    end
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mod_reg      <= '0;
            dirty_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < SLOT_COUNT; k++) begin
                slot_reg[k] <= KEY_NONE;
            end
        end else begin
            state_reg    <= state_next;
            mod_reg      <= mod_next;
            dirty_reg    <= dirty_next;
            m_tvalid_reg <= m_tvalid_next;
            slot_reg     <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        wr_reg         <= wr_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        code_reg       <= code_next;
        pressed_reg    <= pressed_next;
        rep_reg        <= rep_next;
        m_tdata_reg    <= m_tdata_next;
    end

`ifndef NO_ASSERTIONS
    // The compaction write pointer never passes the read index.
    a_wr_behind_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMPACT) |-> (wr_reg <= WR_W'(idx_reg)))
        else $error("compaction write pointer ahead of read index");

    // A new report always leaves the change flag clear.
    a_report_clears_dirty: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> !dirty_reg)
        else $error("report emitted with change flag still set");

    // After compaction the first slot is empty only if the report starts empty.
    a_slot0_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |->
            ((m_tdata_reg[2*CODE_W-1:CODE_W] == KEY_NONE) == (slot_reg[0] == KEY_NONE)))
        else $error("report slot0 disagrees with compacted table");

    // The scan advances one slot per cycle and ends in the update step.
    a_scan_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |=>
            ((state_reg == ST_SCAN && idx_reg == $past(idx_reg) + 1'b1) ||
             state_reg == ST_APPLY))
        else $error("slot scan did not advance");
`endif

endmodule

`default_nettype wire
